// ===== hdl/rate_monotonic_ready_queue_unit_macros.svh =====
// Assertion helpers used by rmrq_dp.
`ifndef RATE_MONOTONIC_READY_QUEUE_UNIT_MACROS_SVH
`define RATE_MONOTONIC_READY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RMRQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RMRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmrq_pkg;

    localparam int MAX_THREADS    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int PERIOD_BITS    = 16;
    localparam int SLOT_BITS      = $clog2(MAX_THREADS);
    localparam int CNT_BITS       = $clog2(MAX_THREADS + 1);

    localparam int IN_BITS   = 3 + THREAD_ID_BITS + PERIOD_BITS + 3;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 2 + THREAD_ID_BITS + 3 + CNT_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALWAYS_BLOCK_WAKE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PREEMPTIVE_MODE   = 1'd1;

    // event codes
    localparam logic [2:0] FN_NEW      = 3'd0;
    localparam logic [2:0] FN_UNBLOCK  = 3'd1;
    localparam logic [2:0] FN_SET      = 3'd2;
    localparam logic [2:0] FN_EXIT     = 3'd3;
    localparam logic [2:0] FN_DISPATCH = 3'd4;
    localparam logic [2:0] FN_OUTCOME  = 3'd5;

    // bounds of the outcome code range (inclusive) that requeues the running thread
    localparam logic [2:0] OC_PREEMPTED = 3'd2;
    localparam logic [2:0] OC_MESSAGE   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_RUN  = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_STATUS,
        OP_SEL_FOUND,
        OP_ALLOC,
        OP_SEL_HEAD,
        OP_SEL_RUN,
        OP_CLR_RUN,
        OP_REMOVE,
        OP_SETPER,
        OP_FREE,
        OP_DISP,
        OP_WALK_INIT,
        OP_STEP,
        OP_INSERT,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       found;
        logic       free_ok;
        logic       len_zero;
        logic       len_full;
        logic       run_valid;
        logic       requeue_ok;
        logic       tgt_queued;
        logic       was_queued;
        logic       walk_end;
        logic       walk_hit;
    } stat_t;

endpackage
`default_nettype wire

// ===== hdl/rmrq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmrq_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rmrq_pkg::cmd_t                         cmd,
    output rmrq_pkg::stat_t                             stat,
    input  wire logic [rmrq_pkg::IN_BYTES*8-1:0]        in_data,
    output logic      [rmrq_pkg::OUT_BYTES*8-1:0]       out_data,
    input  wire logic                                   cfg_we,
    input  wire logic [rmrq_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
    input  wire logic                                   cfg_val
);
    import rmrq_pkg::*;
    `include "rate_monotonic_ready_queue_unit_macros.svh"

    logic [2:0]                func_reg;
    logic [THREAD_ID_BITS-1:0] id_reg;
    logic [PERIOD_BITS-1:0]    per_reg;
    logic [2:0]                oc_reg;

    logic [MAX_THREADS-1:0]    used_reg, queued_reg;
    logic [THREAD_ID_BITS-1:0] thread_reg [MAX_THREADS];
    logic [PERIOD_BITS-1:0]    period_reg [MAX_THREADS];
    logic [SLOT_BITS-1:0]      order_reg  [MAX_THREADS];
    logic [CNT_BITS-1:0]       len_reg;
    logic [SLOT_BITS-1:0]      run_slot_reg;
    logic                      run_valid_reg;

    logic [SLOT_BITS-1:0]      tgt_reg;
    logic [CNT_BITS-1:0]       cursor_reg;
    logic                      was_queued_reg;
    logic                      abw_reg, pm_reg;

    logic [1:0]                st_reg;
    logic [THREAD_ID_BITS-1:0] chosen_reg;
    logic                      cvalid_reg, wob_reg, timed_reg;
    logic [OUT_BITS-1:0]       out_reg;

    // lookup by id, lowest free slot and queue position of the target
    logic [SLOT_BITS-1:0] found_idx, free_idx, rm_pos;
    logic                 found, free_ok, rm_hit;
    always_comb
    begin
        found_idx = '0;
        free_idx  = '0;
        rm_pos    = '0;
        found     = 1'b0;
        free_ok   = 1'b0;
        rm_hit    = 1'b0;
        for (int i = MAX_THREADS - 1; i >= 0; i--)
        begin
            if (used_reg[i] && thread_reg[i] == id_reg)
            begin
                found     = 1'b1;
                found_idx = SLOT_BITS'(i);
            end
            if (!used_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
            if (CNT_BITS'(i) < len_reg && order_reg[i] == tgt_reg)
            begin
                rm_hit = 1'b1;
                rm_pos = SLOT_BITS'(i);
            end
        end
    end

    logic [SLOT_BITS-1:0] cur_idx;
    assign cur_idx = cursor_reg[SLOT_BITS-1:0];

    // compare target period against the entry under the walk cursor
    logic per_reg_tgt_le;
    assign per_reg_tgt_le = period_reg[tgt_reg] <= period_reg[order_reg[cur_idx]];

    always_comb
    begin
        stat.func       = func_reg;
        stat.found      = found;
        stat.free_ok    = free_ok;
        stat.len_zero   = (len_reg == '0);
        stat.len_full   = (len_reg >= CNT_BITS'(MAX_THREADS));
        stat.run_valid  = run_valid_reg;
        stat.requeue_ok = (oc_reg inside {[OC_PREEMPTED:OC_MESSAGE]}) && used_reg[run_slot_reg];
        stat.tgt_queued = queued_reg[tgt_reg];
        stat.was_queued = was_queued_reg;
        stat.walk_end   = (cursor_reg == len_reg);
        stat.walk_hit   = per_reg_tgt_le;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            queued_reg    <= '0;
            len_reg       <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            abw_reg       <= 1'b1;
            pm_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_ALWAYS_BLOCK_WAKE: abw_reg <= cfg_val;
                    CFG_PREEMPTIVE_MODE:   pm_reg  <= cfg_val;
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_ALLOC:
                begin
                    used_reg[free_idx]   <= 1'b1;
                    queued_reg[free_idx] <= 1'b0;
                end
                OP_SEL_RUN, OP_CLR_RUN: run_valid_reg <= 1'b0;
                OP_REMOVE:
                begin
                    if (queued_reg[tgt_reg])
                    begin
                        queued_reg[tgt_reg] <= 1'b0;
                        if (rm_hit)
                            len_reg <= len_reg - 1'b1;
                    end
                end
                OP_FREE:
                begin
                    used_reg[tgt_reg] <= 1'b0;
                    if (run_valid_reg && run_slot_reg == tgt_reg)
                        run_valid_reg <= 1'b0;
                end
                OP_DISP:
                begin
                    run_slot_reg  <= tgt_reg;
                    run_valid_reg <= 1'b1;
                end
                OP_INSERT:
                begin
                    queued_reg[tgt_reg] <= 1'b1;
                    len_reg             <= len_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload and table contents
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                func_reg   <= in_data[2:0];
                id_reg     <= in_data[3 +: THREAD_ID_BITS];
                per_reg    <= in_data[3 + THREAD_ID_BITS +: PERIOD_BITS];
                oc_reg     <= in_data[3 + THREAD_ID_BITS + PERIOD_BITS +: 3];
                st_reg     <= ST_OK;
                chosen_reg <= '0;
                cvalid_reg <= 1'b0;
                wob_reg    <= 1'b0;
                timed_reg  <= 1'b0;
            end
            OP_STATUS:    st_reg  <= cmd.status;
            OP_SEL_FOUND: tgt_reg <= found_idx;
            OP_ALLOC:
            begin
                tgt_reg              <= free_idx;
                thread_reg[free_idx] <= id_reg;
            end
            OP_SEL_HEAD:  tgt_reg <= order_reg[0];
            OP_SEL_RUN:   tgt_reg <= run_slot_reg;
            OP_REMOVE:
            begin
                was_queued_reg <= queued_reg[tgt_reg];
                if (queued_reg[tgt_reg] && rm_hit)
                begin
                    for (int i = 0; i < MAX_THREADS - 1; i++)
                        if (SLOT_BITS'(i) >= rm_pos)
                            order_reg[i] <= order_reg[i + 1];
                end
            end
            OP_SETPER:    period_reg[tgt_reg] <= per_reg;
            OP_DISP:
            begin
                chosen_reg <= thread_reg[tgt_reg];
                cvalid_reg <= 1'b1;
                wob_reg    <= abw_reg || (len_reg != '0);
                timed_reg  <= pm_reg;
            end
            OP_WALK_INIT: cursor_reg <= '0;
            OP_STEP:      cursor_reg <= cursor_reg + 1'b1;
            OP_INSERT:
            begin
                for (int i = 0; i < MAX_THREADS; i++)
                begin
                    if (CNT_BITS'(i) == cursor_reg)
                        order_reg[i] <= tgt_reg;
                    else if (CNT_BITS'(i) > cursor_reg && i > 0)
                        order_reg[i] <= order_reg[i - 1];
                end
            end
            OP_LOAD_OUT:
                out_reg <= {len_reg, timed_reg, wob_reg, cvalid_reg, chosen_reg, st_reg};
            default: ;
        endcase
    end

    assign out_data = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_reg};

    `RMRQ_ASSERT_IMPL(a_len_range, 1'b1, len_reg <= CNT_BITS'(MAX_THREADS), "queue length overflow")
    `RMRQ_ASSERT_IMPL(a_len_marks, 1'b1, $countones(queued_reg) == int'(len_reg), "queue marks disagree")
    `RMRQ_ASSERT_IMPL(a_queued_used, 1'b1, (queued_reg & ~used_reg) == '0, "queued slot not in use")
    `RMRQ_ASSERT_NEXT(a_insert_grow, cmd.op == OP_INSERT, len_reg == $past(len_reg) + 1'b1, "insert lost")

endmodule
`default_nettype wire

// ===== hdl/rmrq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmrq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire rmrq_pkg::stat_t stat,
    output rmrq_pkg::cmd_t      cmd
);
    import rmrq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_REMOVE, S_SETPER, S_FREE, S_DISP, S_WSTART, S_WALK, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NONE, status: ST_OK};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.func)
                    FN_NEW:
                    begin
                        if (stat.found)
                        begin
                            cmd.op     = OP_SEL_FOUND;
                            state_next = S_REMOVE;
                        end
                        else if (stat.free_ok)
                        begin
                            cmd.op     = OP_ALLOC;
                            state_next = S_SETPER;
                        end
                        else
                            cmd = '{op: OP_STATUS, status: ST_FULL};
                    end
                    FN_UNBLOCK, FN_SET, FN_EXIT:
                    begin
                        if (stat.found)
                        begin
                            cmd.op     = OP_SEL_FOUND;
                            state_next = (stat.func == FN_UNBLOCK) ? S_WSTART : S_REMOVE;
                        end
                        else
                            cmd = '{op: OP_STATUS, status: ST_UNKNOWN};
                    end
                    FN_DISPATCH:
                    begin
                        if (stat.len_zero)
                            cmd.op = OP_CLR_RUN;
                        else
                        begin
                            cmd.op     = OP_SEL_HEAD;
                            state_next = S_REMOVE;
                        end
                    end
                    FN_OUTCOME:
                    begin
                        if (!stat.run_valid)
                            cmd = '{op: OP_STATUS, status: ST_NO_RUN};
                        else if (stat.requeue_ok)
                        begin
                            cmd.op     = OP_SEL_RUN;
                            state_next = S_WSTART;
                        end
                        else
                            cmd.op = OP_CLR_RUN;
                    end
                    default: ;
                endcase
            end
            S_REMOVE:
            begin
                cmd.op = OP_REMOVE;
                case (stat.func)
                    FN_EXIT:     state_next = S_FREE;
                    FN_DISPATCH: state_next = S_DISP;
                    default:     state_next = S_SETPER;
                endcase
            end
            S_SETPER:
            begin
                cmd.op     = OP_SETPER;
                state_next = (stat.func == FN_NEW || stat.was_queued) ? S_WSTART : S_DONE;
            end
            S_FREE:
            begin
                cmd.op     = OP_FREE;
                state_next = S_DONE;
            end
            S_DISP:
            begin
                cmd.op     = OP_DISP;
                state_next = S_DONE;
            end
            S_WSTART:
            begin
                if (stat.tgt_queued || stat.len_full)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = OP_WALK_INIT;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.walk_end || stat.walk_hit)
                begin
                    cmd.op     = OP_INSERT;
                    state_next = S_DONE;
                end
                else
                    cmd.op = OP_STEP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/rate_monotonic_ready_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                   Payload
// s_axis    s_axis_tvalid/tready        s_axis_tdata: one scheduling event
// m_axis    m_axis_tvalid/tready        m_axis_tdata: one result per event
// cfg       cfg_valid/cfg_ready         cfg_index, cfg_data
//
// Each event passes through latch, decode, its table steps and, when a thread is
// to be queued, a sorted-insert walk that reads one queue entry per cycle.
// Reset clears the slot table marks, queue length and running mark at once.
// A finished result sits in the output register; the next event is taken
// while it waits, and only the final load stalls until m_axis is free.
// Config writes are always ready and take effect the next cycle.
module rate_monotonic_ready_queue_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] func, [10:3] thread_id, [26:11] period_value, [29:27] outcome_code
    input  wire logic [rmrq_pkg::IN_BYTES*8-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [9:2] chosen_thread, [10] chosen_valid, [11] wake_on_block,
    // [12] timed_donation, [17:13] ready_count
    output logic      [rmrq_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rmrq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic                           cfg_data
);
    import rmrq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer: walks each event through its table steps
    rmrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // thread table, sorted run queue and result register
    rmrq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_val  (cfg_data)
    );

endmodule
`default_nettype wire
